// File: hw/rtl/pmlb_pkg.sv
package pmlb_pkg;

  localparam int MAX_NODES_DEF    = 16;
  localparam int WEIGHT_BITS_DEF  = 16;
  localparam int COST_W           = 20;
  localparam int BOUND_W          = 21;
  localparam int NODE_COUNT_W     = 5;
  localparam int MASK_W           = 16;
  localparam int PADDR_W          = 3;
  localparam int PDATA_W          = 32;

  localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RST = 5'd16;

  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  localparam logic REG_NODE_COUNT = 1'b0;

  typedef struct packed {
    logic                cmd;
    logic [3:0]          row;
    logic [3:0]          col;
    logic [15:0]         weight;
    logic [MASK_W-1:0]   visited_mask;
    logic [COST_W-1:0]   path_cost;
  } item_t;

  typedef struct packed {
    logic [COST_W-1:0]  mst_cost;
    logic [BOUND_W-1:0] lower_bound;
  } result_t;

  typedef struct packed {
    logic load;
    logic wr_edge;
    logic scan_rd;
    logic commit;
    logic upd_rd;
    logic out_load;
  } pmlb_cmd_t;

  typedef struct packed {
    logic found;
  } pmlb_status_t;

endpackage

// File: hw/rtl/pmlb_dp.sv
module pmlb_dp #(
  parameter int MAX_NODES   = pmlb_pkg::MAX_NODES_DEF,
  parameter int WEIGHT_BITS = pmlb_pkg::WEIGHT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pmlb_pkg::pmlb_cmd_t           cmd,
  input  logic [$clog2(MAX_NODES)-1:0]  idx,
  input  pmlb_pkg::item_t               item,
  output pmlb_pkg::pmlb_status_t        status,
  output pmlb_pkg::result_t             result
);
  import pmlb_pkg::*;

  localparam int IW    = $clog2(MAX_NODES);
  localparam int EW    = $clog2(MAX_NODES * MAX_NODES);
  localparam int DEPTH = MAX_NODES * MAX_NODES;
  localparam logic [WEIGHT_BITS-1:0] NO_EDGE = {WEIGHT_BITS{1'b1}};

  logic [WEIGHT_BITS-1:0] edge_mem [DEPTH];
  logic [WEIGHT_BITS-1:0] key_mem [MAX_NODES];

  logic [WEIGHT_BITS-1:0] edge_q;
  logic [WEIGHT_BITS-1:0] key_q;
  logic [IW-1:0]          idx_d;
  logic                   scan_v;
  logic                   upd_v;

  logic [MAX_NODES-1:0]   key_valid;
  logic [MAX_NODES-1:0]   in_tree;
  logic                   first;
  logic                   has_pick;
  logic [WEIGHT_BITS-1:0] best_key;
  logic [IW-1:0]          pick_idx;
  logic [COST_W-1:0]      cost;
  logic [MASK_W-1:0]      mask_q;
  logic [COST_W-1:0]      path_q;
  result_t                result_q;

  logic                   row_ok;
  logic [EW-1:0]          waddr;
  logic [EW-1:0]          raddr;
  logic [MASK_W-1:0]      mask_sh;
  logic                   vis;
  logic [WEIGHT_BITS-1:0] key_eff;
  logic [WEIGHT_BITS-1:0] scan_key;
  logic                   take;
  logic                   relax;

  assign row_ok = (32'(item.row) < MAX_NODES) && (32'(item.col) < MAX_NODES);
  assign waddr  = EW'(item.row) * EW'(MAX_NODES) + EW'(item.col);
  assign raddr  = EW'(pick_idx) * EW'(MAX_NODES) + EW'(idx);

  assign mask_sh  = mask_q >> idx_d;
  assign vis      = mask_sh[0];
  assign key_eff  = key_valid[idx_d] ? key_q : NO_EDGE;
  assign scan_key = first ? (vis ? NO_EDGE : '0) : key_eff;
  assign take     = scan_v && !in_tree[idx_d] && (!has_pick || scan_key < best_key);
  assign relax    = upd_v && !in_tree[idx_d] && !vis && (edge_q < key_eff);

  assign status.found = has_pick && (best_key != NO_EDGE);
  assign result       = result_q;

  always_ff @(posedge clk) begin
    if (cmd.wr_edge && row_ok) begin
      edge_mem[waddr] <= WEIGHT_BITS'(item.weight);
    end
    edge_q <= edge_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (relax) begin
      key_mem[idx_d] <= edge_q;
    end
    key_q <= key_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_v    <= 1'b0;
      upd_v     <= 1'b0;
      key_valid <= '0;
      in_tree   <= '0;
      first     <= 1'b0;
      has_pick  <= 1'b0;
    end else begin
      scan_v <= cmd.scan_rd;
      upd_v  <= cmd.upd_rd;
      if (cmd.load) begin
        key_valid <= '0;
        in_tree   <= '0;
        first     <= 1'b1;
        has_pick  <= 1'b0;
      end else if (cmd.commit) begin
        in_tree[pick_idx] <= 1'b1;
        first             <= 1'b0;
        has_pick          <= 1'b0;
      end else if (take) begin
        has_pick <= 1'b1;
      end
      if (relax) begin
        key_valid[idx_d] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_d <= idx;
    if (cmd.load) begin
      mask_q <= item.visited_mask;
      path_q <= item.path_cost;
      cost   <= '0;
    end else if (cmd.commit) begin
      cost <= cost + COST_W'(best_key);
    end
    if (take) begin
      best_key <= scan_key;
      pick_idx <= idx_d;
    end
    if (cmd.out_load) begin
      result_q.mst_cost    <= cost;
      result_q.lower_bound <= BOUND_W'(path_q) + BOUND_W'(cost);
    end
  end

endmodule

// File: hw/rtl/pmlb_ctrl.sv
module pmlb_ctrl #(
  parameter int MAX_NODES = pmlb_pkg::MAX_NODES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [pmlb_pkg::NODE_COUNT_W-1:0]    node_count,
  input  logic                                 item_valid,
  input  logic                                 item_cmd,
  output logic                                 item_ready,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  input  pmlb_pkg::pmlb_status_t               status,
  output pmlb_pkg::pmlb_cmd_t                  cmd,
  output logic [$clog2(MAX_NODES)-1:0]         idx
);
  import pmlb_pkg::*;

  localparam int IW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);

  typedef enum logic [2:0] {
    IDLE,
    SCAN,
    PICK,
    UPDATE,
    DONE
  } state_t;

  state_t        state;
  logic [CW-1:0] cnt;
  logic [CW-1:0] n;
  logic          accept;
  logic          more;

  assign n      = (32'(node_count) > MAX_NODES) ? CW'(MAX_NODES) : CW'(node_count);
  assign more   = cnt < n;
  assign idx    = cnt[IW-1:0];
  assign item_ready = (state == IDLE);
  assign accept = item_valid && item_ready;

  always_comb begin
    cmd          = '0;
    cmd.wr_edge  = accept && (item_cmd == CMD_WRITE);
    cmd.load     = accept && (item_cmd == CMD_COMPUTE);
    cmd.scan_rd  = (state == SCAN) && more;
    cmd.commit   = (state == PICK) && status.found;
    cmd.upd_rd   = (state == UPDATE) && more;
    cmd.out_load = (state == DONE) && (!result_valid || result_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (cmd.load) begin
            state <= SCAN;
            cnt   <= '0;
          end
        end
        SCAN: begin
          if (more) begin
            cnt <= cnt + 1'b1;
          end else begin
            state <= PICK;
          end
        end
        PICK: begin
          cnt <= '0;
          if (status.found) begin
            state <= UPDATE;
          end else begin
            state <= DONE;
          end
        end
        UPDATE: begin
          if (more) begin
            cnt <= cnt + 1'b1;
          end else begin
            state <= SCAN;
            cnt   <= '0;
          end
        end
        DONE: begin
          if (cmd.out_load) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/prim_mst_lower_bound.sv
// Spanning-tree lower bound over the unvisited nodes of a dense weight matrix.
// Input channel (item_valid/item_ready/item): a write transfer (cmd = write)
// stores one matrix entry and returns nothing; a compute transfer carries the
// visited mask and path cost and returns one transfer on the result channel
// (result_valid/result_ready/result) with the tree cost and the lower bound.
// A compute works on n = min(node_count, MAX_NODES) nodes: each tree step
// scans every key once and checks every key once for relaxation, one node
// per cycle through the single read port of the key and edge memories.
// Items are taken one at a time; item_ready is low while a compute runs.
// A finished result sits in an output register, so the next item is taken
// while the receiver stalls; a second result waits in the engine until the
// register frees up. Reset clears control state and sets node_count to 16.
// Matrix entries are undefined until written. The user must set node_count
// over the APB port only while idle; the block itself does not enforce it.
module prim_mst_lower_bound #(
  parameter int MAX_NODES   = pmlb_pkg::MAX_NODES_DEF,
  parameter int WEIGHT_BITS = pmlb_pkg::WEIGHT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  pmlb_pkg::item_t               item,
  output logic                          result_valid,
  input  logic                          result_ready,
  output pmlb_pkg::result_t             result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pmlb_pkg::PADDR_W-1:0]  paddr,
  input  logic [pmlb_pkg::PDATA_W-1:0]  pwdata,
  output logic [pmlb_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import pmlb_pkg::*;

  logic [NODE_COUNT_W-1:0]   node_count;
  logic                      reg_hit;
  pmlb_cmd_t                 cmd;
  pmlb_status_t              status;
  logic [$clog2(MAX_NODES)-1:0] idx;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_NODE_COUNT);
  assign prdata  = reg_hit ? PDATA_W'(node_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RST;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      node_count <= pwdata[NODE_COUNT_W-1:0];
    end
  end

  pmlb_ctrl #(
    .MAX_NODES (MAX_NODES)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .node_count   (node_count),
    .item_valid   (item_valid),
    .item_cmd     (item.cmd),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .cmd          (cmd),
    .idx          (idx)
  );

  pmlb_dp #(
    .MAX_NODES   (MAX_NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .idx    (idx),
    .item   (item),
    .status (status),
    .result (result)
  );

endmodule
